// File: src/plb_pkg.sv
// Shared types and codes for the positional list buffer.
// Used by plb_cell, plb_ctrl and positional_list_buffer; no dependencies.
`timescale 1ns / 1ps

package plb_pkg;

    // Request kinds
    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_REMOVE = 2'd1;
    localparam logic [1:0] KIND_DUMP   = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // Cell operations broadcast along the chain
    typedef logic [1:0] cell_op_t;
    localparam cell_op_t OP_HOLD   = 2'd0;
    localparam cell_op_t OP_INSERT = 2'd1;
    localparam cell_op_t OP_REMOVE = 2'd2;
    localparam cell_op_t OP_ROTATE = 2'd3;

    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;

    typedef struct packed {
        cell_op_t                   op;
        logic [POS_W-1:0]           pos;
        logic [POS_W-1:0]           last_idx;
        logic signed [VALUE_W-1:0]  value;
    } cell_ctl_t;

endpackage

// File: src/plb_cell.sv
// One storage cell of the list chain: holds one entry and moves it to or
// from its neighbors on insert, remove and dump rotation. Depends on plb_pkg.
`timescale 1ns / 1ps

module plb_cell #(
    parameter int IDX = 0
) (
    input  logic                                  clk,
    input  plb_pkg::cell_ctl_t                    ctl,
    input  logic signed [plb_pkg::VALUE_W-1:0]    left_value,
    input  logic signed [plb_pkg::VALUE_W-1:0]    right_value,
    input  logic signed [plb_pkg::VALUE_W-1:0]    head_value,
    output logic signed [plb_pkg::VALUE_W-1:0]    value
);
    import plb_pkg::*;

    localparam logic [POS_W-1:0] MY_IDX = POS_W'(IDX);

    logic signed [VALUE_W-1:0] val_reg;
    logic signed [VALUE_W-1:0] val_next;

    // Pick the new entry from self, neighbor, head or incoming value
    always_comb
    begin
        val_next = val_reg;
        unique case (ctl.op)
            OP_HOLD:
            begin
                val_next = val_reg;
            end
            OP_INSERT:
            begin
                if (MY_IDX == ctl.pos)
                    val_next = ctl.value;
                else if (MY_IDX > ctl.pos)
                    val_next = left_value;
            end
            OP_REMOVE:
            begin
                if (MY_IDX >= ctl.pos)
                    val_next = right_value;
            end
            OP_ROTATE:
            begin
                if (MY_IDX < ctl.last_idx)
                    val_next = right_value;
                else if (MY_IDX == ctl.last_idx)
                    val_next = head_value;
            end
            default:
            begin
                val_next = val_reg;
            end
        endcase
    end

    // Hold the entry
    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    assign value = val_reg;

endmodule

// File: src/plb_ctrl.sv
// Request decoder, entry counter, dump sequencer and result register of
// the positional list buffer. Depends on plb_pkg; drives the plb_cell chain.
`timescale 1ns / 1ps

module plb_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [1:0]                            kind,
    input  logic [plb_pkg::POS_W-1:0]             position,
    input  logic signed [plb_pkg::VALUE_W-1:0]    item_value,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [1:0]                            status,
    output logic signed [plb_pkg::VALUE_W-1:0]    entry_value,
    output logic [plb_pkg::POS_W-1:0]             entry_count,
    output logic                                  last,
    input  logic signed [plb_pkg::VALUE_W-1:0]    head_value,
    output plb_pkg::cell_ctl_t                    ctl
);
    import plb_pkg::*;

    localparam logic [POS_W-1:0] CAP_N = POS_W'(CAPACITY);
    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    logic                      state_reg,    state_next;
    logic [POS_W-1:0]          count_reg,    count_next;
    logic [POS_W-1:0]          remain_reg,   remain_next;
    logic                      ovalid_reg,   ovalid_next;
    logic [1:0]                ostatus_reg,  ostatus_next;
    logic signed [VALUE_W-1:0] ovalue_reg,   ovalue_next;
    logic [POS_W-1:0]          ocount_reg,   ocount_next;
    logic                      olast_reg,    olast_next;

    logic out_free;
    logic accept;

    assign out_free = !ovalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign accept   = s_tvalid && s_tready;

    // Decode requests, step the dump and build the next result
    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        remain_next  = remain_reg;
        ovalid_next  = ovalid_reg;
        ostatus_next = ostatus_reg;
        ovalue_next  = ovalue_reg;
        ocount_next  = ocount_reg;
        olast_next   = olast_reg;

        ctl.op       = OP_HOLD;
        ctl.pos      = position;
        ctl.last_idx = count_reg - POS_W'(1);
        ctl.value    = item_value;

        if (out_free)
            ovalid_next = 1'b0;

        priority if (accept)
        begin
            ovalid_next  = 1'b1;
            ostatus_next = ST_OK;
            ovalue_next  = '0;
            olast_next   = 1'b1;
            unique case (kind)
                KIND_INSERT:
                begin
                    if (count_reg >= CAP_N)
                        ostatus_next = ST_FULL;
                    else if (position > count_reg)
                        ostatus_next = ST_RANGE;
                    else
                    begin
                        ctl.op     = OP_INSERT;
                        count_next = count_reg + POS_W'(1);
                    end
                end
                KIND_REMOVE:
                begin
                    if (count_reg == '0)
                        ostatus_next = ST_EMPTY;
                    else if (position >= count_reg)
                        ostatus_next = ST_RANGE;
                    else
                    begin
                        ctl.op     = OP_REMOVE;
                        count_next = count_reg - POS_W'(1);
                    end
                end
                KIND_DUMP:
                begin
                    if (count_reg == '0)
                        ostatus_next = ST_EMPTY;
                    else
                    begin
                        // Emit the head now and rotate the rest forward
                        ctl.op      = OP_ROTATE;
                        ovalue_next = head_value;
                        olast_next  = (count_reg == POS_W'(1));
                        remain_next = count_reg - POS_W'(1);
                        if (count_reg != POS_W'(1))
                            state_next = ST_DUMP;
                    end
                end
                default:
                begin
                    ostatus_next = ST_OK;
                end
            endcase
            ocount_next = count_next;
        end
        else if ((state_reg == ST_DUMP) && out_free)
        begin
            // Advance the dump by one entry
            ctl.op       = OP_ROTATE;
            ovalid_next  = 1'b1;
            ostatus_next = ST_OK;
            ovalue_next  = head_value;
            ocount_next  = count_reg;
            olast_next   = (remain_reg == POS_W'(1));
            remain_next  = remain_reg - POS_W'(1);
            if (remain_reg == POS_W'(1))
                state_next = ST_IDLE;
        end
        else
        begin
            // Hold the sequencer while idle or stalled
            state_next = state_reg;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            count_reg  <= '0;
            remain_reg <= '0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            remain_reg <= remain_next;
            ovalid_reg <= ovalid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        ostatus_reg <= ostatus_next;
        ovalue_reg  <= ovalue_next;
        ocount_reg  <= ocount_next;
        olast_reg   <= olast_next;
    end

    assign m_tvalid    = ovalid_reg;
    assign status      = ostatus_reg;
    assign entry_value = ovalue_reg;
    assign entry_count = ocount_reg;
    assign last        = olast_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_N)
        else $error("entry count above capacity");

    a_dump_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> !s_tready)
        else $error("request taken during dump");

    a_dump_remain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DUMP) |-> (remain_reg != '0))
        else $error("dump running with nothing left");

    a_nonlast_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
        (ovalid_reg && !olast_reg) |-> (state_reg == ST_DUMP))
        else $error("non-final result outside dump");

endmodule

// File: src/positional_list_buffer.sv
// Positional list buffer: bounded ordered list of signed 32-bit entries.
// Insert, remove and other requests: one result, registered in the cycle after
// acceptance; the next request is taken as soon as the result register frees.
// Dump: count results, one per cycle unless m_tready stalls, from the cell chain head,
// which rotates once per result; no request is taken until the final one is sent.
// Reset (rst_n, async, active low) empties the list; entry cells are not cleared.
`timescale 1ns / 1ps

module positional_list_buffer #(
    parameter int CAPACITY = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] position, [38:7] item_value, [39] zero
    input  logic [1:0]  s_tuser,   // [1:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] entry_value, [38:32] entry_count, [39] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);
    import plb_pkg::*;

    cell_ctl_t                 ctl;
    logic signed [VALUE_W-1:0] cell_value [CAPACITY];
    logic signed [VALUE_W-1:0] entry_value;
    logic [POS_W-1:0]          entry_count;

    // Sequence requests and hold the result
    plb_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .kind        (s_tuser),
        .position    (s_tdata[6:0]),
        .item_value  (s_tdata[38:7]),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .status      (m_tuser),
        .entry_value (entry_value),
        .entry_count (entry_count),
        .last        (m_tlast),
        .head_value  (cell_value[0]),
        .ctl         (ctl)
    );

    // Chain of entry cells, each wired to its neighbors
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [VALUE_W-1:0] left_v;
        logic signed [VALUE_W-1:0] right_v;

        if (i == 0)
        begin : g_first
            assign left_v = cell_value[i];
        end
        else
        begin : g_left
            assign left_v = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_end
            assign right_v = cell_value[i];
        end
        else
        begin : g_right
            assign right_v = cell_value[i+1];
        end

        plb_cell #(
            .IDX(i)
        ) u_cell (
            .clk         (clk),
            .ctl         (ctl),
            .left_value  (left_v),
            .right_value (right_v),
            .head_value  (cell_value[0]),
            .value       (cell_value[i])
        );
    end

    assign m_tdata = {1'b0, entry_count, entry_value};

endmodule
